// ===== rtl/pcxrle_pkg.sv =====
package pcxrle_pkg;

    // Field widths.
    localparam int DATA_W     = 8;
    localparam int RUN_W      = 6;
    localparam int COL_W      = 13;
    localparam int LEN_W      = 14;
    localparam int ROW_W      = 17;
    localparam int ROW_OUT_W  = 16;
    localparam int WIDTH_W    = 17;
    localparam int PIX_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int M_TDATA_W  = 48;

    // Line length limits.
    localparam logic [LEN_W-1:0] MAX_LINE_BYTES = 14'd8192;
    localparam logic [LEN_W-1:0] MIN_LINE_BYTES = 14'd1;

    // Register reset values.
    localparam logic [LEN_W-1:0]   RST_BYTES_PER_LINE = 14'd80;
    localparam logic [WIDTH_W-1:0] RST_IMAGE_WIDTH    = 17'd640;
    localparam logic [ROW_W-1:0]   RST_IMAGE_HEIGHT   = 17'd480;

    // A byte with both top bits set carries a run count.
    localparam logic [1:0] RUN_MARK = 2'b11;

    // Pixels per encoded byte.
    localparam logic [PIX_W-1:0] PIX_PER_BYTE = 4'd8;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BYTES_PER_LINE = 2'd0,
        CFG_IMAGE_WIDTH    = 2'd1,
        CFG_IMAGE_HEIGHT   = 2'd2
    } cfg_idx_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_count;  // store a run count, wait for its data byte
        logic clear_await; // the run data byte has arrived
        logic emit;        // load one result into the output register
        logic src_held;    // result byte comes from the held run byte
        logic load_run;    // hold the input byte and the remaining run count
        logic dec_run;     // one more repeated byte sent
        logic last;        // result is the final one for its input byte
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic slot_free;    // output register can take a result this cycle
        logic complete;     // all rows decoded
        logic awaiting;     // a run count is waiting for its data byte
        logic count_byte;   // input byte is a run count
        logic pending_zero; // stored run count is zero
        logic pending_one;  // stored run count is one
        logic run_left_one; // one repeated byte is left to send
        logic line_end;     // the next result closes the line
    } sts_t;

endpackage

// ===== rtl/pcx_1bpp_rle_decoder.sv =====
// Channel  Direction  Handshake            Payload
// s_       in         s_tvalid/s_tready    s_tdata: data_byte
// m_       out        m_tvalid/m_tready    m_tdata: pixel_bits, row_index, byte_column,
//                                          pixels_in_width; m_tlast; m_tuser
// cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A run of n bytes sends up to n results, fewer at a line end, one per cycle
// while the output register has room, with the input stalled until the last
// one is out. The output register and its handshake set the rate: a stalled
// m_tready holds both the result and, once the register is full, the input.
// Synchronous reset on aresetn clears run and position state; no clearing pass.
module pcx_1bpp_rle_decoder (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [7:0]                            s_tdata,  // [7:0] data_byte
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [7:0] pixel_bits, [23:8] row_index, [36:24] byte_column,
    // [40:37] pixels_in_width, [47:41] zero
    output logic [pcxrle_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                  m_tlast,  // last_of_run
    output logic                                  m_tuser,  // [0] image_done
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pcxrle_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pcxrle_pkg::CFG_DATA_W-1:0]     cfg_data
);

    pcxrle_pkg::cmd_t cmd;
    pcxrle_pkg::sts_t sts;

    logic [pcxrle_pkg::DATA_W-1:0]    out_pixels;
    logic [pcxrle_pkg::ROW_OUT_W-1:0] out_row;
    logic [pcxrle_pkg::COL_W-1:0]     out_col;
    logic [pcxrle_pkg::PIX_W-1:0]     out_visible;

    // Registers are written whenever offered.
    assign cfg_ready = 1'b1;

    pcxrle_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pcxrle_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_byte     (s_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .sts         (sts),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .out_pixels  (out_pixels),
        .out_row     (out_row),
        .out_col     (out_col),
        .out_visible (out_visible),
        .out_last    (m_tlast),
        .out_done    (m_tuser)
    );

    // Result packing, first field in the low bits.
    assign m_tdata = {7'd0, out_visible, out_col, out_row, out_pixels};

endmodule

// ===== rtl/pcxrle_ctrl.sv =====
module pcxrle_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  pcxrle_pkg::sts_t  sts,
    output pcxrle_pkg::cmd_t  cmd
);

    typedef enum logic {
        ST_ACCEPT,
        ST_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // Input is taken only between runs and when a result has room.
    assign s_tready = (state_reg == ST_ACCEPT) && sts.slot_free;
    assign accept   = s_tready && s_tvalid;

    // Decode decisions.
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_ACCEPT: begin
                if (accept && !sts.complete) begin
                    if (sts.awaiting) begin
                        cmd.clear_await = 1'b1;
                        if (!sts.pending_zero) begin
                            cmd.emit     = 1'b1;
                            cmd.load_run = 1'b1;
                            cmd.last     = sts.line_end || sts.pending_one;
                            if (!cmd.last) begin
                                state_next = ST_RUN;
                            end
                        end
                    end else if (sts.count_byte) begin
                        cmd.load_count = 1'b1;
                    end else begin
                        cmd.emit = 1'b1;
                        cmd.last = 1'b1;
                    end
                end
            end
            ST_RUN: begin
                if (sts.slot_free) begin
                    cmd.emit     = 1'b1;
                    cmd.src_held = 1'b1;
                    cmd.dec_run  = 1'b1;
                    cmd.last     = sts.line_end || sts.run_left_one;
                    if (cmd.last) begin
                        state_next = ST_ACCEPT;
                    end
                end
            end
            default: begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCEPT;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    // The final result of a byte always returns the controller to taking input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.last) |=> (state_reg == ST_ACCEPT))
        else $error("controller did not leave run after final result");

    // While a run repeats, no run count is waiting for data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> !sts.awaiting)
        else $error("run count pending during run output");
`endif

endmodule

// ===== rtl/pcxrle_datapath.sv =====
module pcxrle_datapath (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic [pcxrle_pkg::DATA_W-1:0]          in_byte,
    input  logic                                   cfg_valid,
    input  logic [pcxrle_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pcxrle_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  pcxrle_pkg::cmd_t                       cmd,
    output pcxrle_pkg::sts_t                       sts,
    input  logic                                   m_tready,
    output logic                                   m_tvalid,
    output logic [pcxrle_pkg::DATA_W-1:0]          out_pixels,
    output logic [pcxrle_pkg::ROW_OUT_W-1:0]       out_row,
    output logic [pcxrle_pkg::COL_W-1:0]           out_col,
    output logic [pcxrle_pkg::PIX_W-1:0]           out_visible,
    output logic                                   out_last,
    output logic                                   out_done
);

    // Configuration.
    logic [pcxrle_pkg::LEN_W-1:0]   line_len_reg;
    logic [pcxrle_pkg::WIDTH_W-1:0] width_reg;
    logic [pcxrle_pkg::ROW_W-1:0]   height_reg;
    logic [pcxrle_pkg::LEN_W-1:0]   cfg_len;

    // Decode state.
    logic                             awaiting_reg;
    logic [pcxrle_pkg::RUN_W-1:0]     pending_reg;
    logic [pcxrle_pkg::RUN_W-1:0]     run_left_reg;
    logic [pcxrle_pkg::DATA_W-1:0]    held_reg;
    logic [pcxrle_pkg::COL_W-1:0]     line_cnt_reg;
    logic [pcxrle_pkg::ROW_W-1:0]     row_reg;

    // Output register.
    logic                              m_valid_reg;
    logic [pcxrle_pkg::DATA_W-1:0]     pix_reg;
    logic [pcxrle_pkg::ROW_OUT_W-1:0]  row_out_reg;
    logic [pcxrle_pkg::COL_W-1:0]      col_out_reg;
    logic [pcxrle_pkg::PIX_W-1:0]      vis_reg;
    logic                              last_reg;
    logic                              done_reg;

    // Per-result values.
    logic [pcxrle_pkg::LEN_W-1:0]      cnt_plus;
    logic                              line_end;
    logic [pcxrle_pkg::ROW_W-1:0]      row_next;
    logic [pcxrle_pkg::WIDTH_W-1:0]    first_px;
    logic [pcxrle_pkg::WIDTH_W-1:0]    px_left;
    logic [pcxrle_pkg::PIX_W-1:0]      visible;
    logic [pcxrle_pkg::DATA_W-1:0]     emit_byte;

    // Line length clamped into one to the maximum line size.
    always_comb begin
        cfg_len = cfg_data[pcxrle_pkg::LEN_W-1:0];
        if (cfg_len == '0) begin
            cfg_len = pcxrle_pkg::MIN_LINE_BYTES;
        end else if (cfg_len > pcxrle_pkg::MAX_LINE_BYTES) begin
            cfg_len = pcxrle_pkg::MAX_LINE_BYTES;
        end
    end

    // Line end and row advance for the result about to be sent.
    assign cnt_plus = {1'b0, line_cnt_reg} + pcxrle_pkg::LEN_W'(1);
    assign line_end = cnt_plus >= line_len_reg;
    assign row_next = row_reg + pcxrle_pkg::ROW_W'(1);

    // Pixels of this byte that fall inside the image width.
    assign first_px = {1'b0, line_cnt_reg, 3'b000};
    assign px_left  = width_reg - first_px;
    always_comb begin
        if (width_reg <= first_px) begin
            visible = '0;
        end else if (px_left >= pcxrle_pkg::WIDTH_W'(pcxrle_pkg::PIX_PER_BYTE)) begin
            visible = pcxrle_pkg::PIX_PER_BYTE;
        end else begin
            visible = px_left[pcxrle_pkg::PIX_W-1:0];
        end
    end

    assign emit_byte = cmd.src_held ? held_reg : in_byte;

    // Status to the controller.
    always_comb begin
        sts              = '0;
        sts.slot_free    = !m_valid_reg || m_tready;
        sts.complete     = row_reg >= height_reg;
        sts.awaiting     = awaiting_reg;
        sts.count_byte   = in_byte[pcxrle_pkg::DATA_W-1 -: 2] == pcxrle_pkg::RUN_MARK;
        sts.pending_zero = pending_reg == '0;
        sts.pending_one  = pending_reg == pcxrle_pkg::RUN_W'(1);
        sts.run_left_one = run_left_reg == pcxrle_pkg::RUN_W'(1);
        sts.line_end     = line_end;
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_len_reg <= pcxrle_pkg::RST_BYTES_PER_LINE;
            width_reg    <= pcxrle_pkg::RST_IMAGE_WIDTH;
            height_reg   <= pcxrle_pkg::RST_IMAGE_HEIGHT;
        end else if (cfg_valid) begin
            case (pcxrle_pkg::cfg_idx_t'(cfg_index))
                pcxrle_pkg::CFG_BYTES_PER_LINE: line_len_reg <= cfg_len;
                pcxrle_pkg::CFG_IMAGE_WIDTH:    width_reg    <= cfg_data;
                pcxrle_pkg::CFG_IMAGE_HEIGHT:   height_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Run bookkeeping and position counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            awaiting_reg <= 1'b0;
            pending_reg  <= '0;
            run_left_reg <= '0;
            line_cnt_reg <= '0;
            row_reg      <= '0;
        end else begin
            if (cmd.load_count) begin
                awaiting_reg <= 1'b1;
                pending_reg  <= in_byte[pcxrle_pkg::RUN_W-1:0];
            end else if (cmd.clear_await) begin
                awaiting_reg <= 1'b0;
            end
            if (cmd.load_run) begin
                run_left_reg <= pending_reg - pcxrle_pkg::RUN_W'(1);
            end else if (cmd.dec_run) begin
                run_left_reg <= run_left_reg - pcxrle_pkg::RUN_W'(1);
            end
            if (cmd.emit) begin
                if (line_end) begin
                    line_cnt_reg <= '0;
                    row_reg      <= row_next;
                end else begin
                    line_cnt_reg <= cnt_plus[pcxrle_pkg::COL_W-1:0];
                end
            end
        end
    end

    // Held run byte.
    always_ff @(posedge aclk) begin
        if (cmd.load_run) begin
            held_reg <= in_byte;
        end
    end

    // Output register: a result waits here until its transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            pix_reg     <= emit_byte;
            row_out_reg <= row_reg[pcxrle_pkg::ROW_OUT_W-1:0];
            col_out_reg <= line_cnt_reg;
            vis_reg     <= visible;
            last_reg    <= cmd.last;
            done_reg    <= line_end && (row_next >= height_reg);
        end
    end

    assign m_tvalid    = m_valid_reg;
    assign out_pixels  = pix_reg;
    assign out_row     = row_out_reg;
    assign out_col     = col_out_reg;
    assign out_visible = vis_reg;
    assign out_last    = last_reg;
    assign out_done    = done_reg;

`ifndef SYNTHESIS
    // A result that closes a line restarts the byte count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && line_end) |=> (line_cnt_reg == '0))
        else $error("line count not cleared at line end");

    // Rows advance only with a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.emit |=> $stable(row_reg))
        else $error("row changed without a result");
`endif

endmodule

// ===== verif/pcx_1bpp_rle_decoder_test.sv =====
module pcx_1bpp_rle_decoder_test;
    import pcxrle_pkg::*;

    // Register index that selects no register; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    // Idle cycles allowed before a configuration write.
    localparam int SETTLE_CYCLES = 8;
    // Cycles without any transfer before the run is declared hung.
    localparam int HANG_LIMIT = 4000;
    // Widest register value, used for the upper extremes.
    localparam logic [CFG_DATA_W-1:0] CFG_ALL_ONES = 17'h1FFFF;

    // One decoded byte as the block should present it.
    typedef struct {
        logic [7:0]  pixels;
        logic [15:0] row;
        logic [12:0] col;
        logic [3:0]  vis;
        bit          last;
        bit          done;
    } pixel_word_t;

    // Scoreboard: decodes the byte stream on its own and matches the results.
    class rle_pixel_predictor;
        logic [LEN_W-1:0]   bytes_per_line;
        logic [WIDTH_W-1:0] image_width;
        logic [ROW_W-1:0]   image_height;
        bit                 run_pending;
        logic [RUN_W-1:0]   run_length;
        logic [COL_W-1:0]   line_bytes;
        logic [ROW_W-1:0]   row;
        pixel_word_t        expected_pixels[$];
        int                 mismatches;

        function new();
            bytes_per_line = RST_BYTES_PER_LINE;
            image_width    = RST_IMAGE_WIDTH;
            image_height   = RST_IMAGE_HEIGHT;
            run_pending    = 0;
            run_length     = '0;
            line_bytes     = '0;
            row            = '0;
            mismatches     = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_BYTES_PER_LINE: bytes_per_line = value[LEN_W-1:0];
                CFG_IMAGE_WIDTH:    image_width = value[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT:   image_height = value[ROW_W-1:0];
                default: ;
            endcase
        endfunction

        function bit image_complete();
            return row >= image_height;
        endfunction

        function logic [ROW_W-1:0] rows_done();
            return row;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        // Effective line length: zero counts as one, large values saturate.
        function int unsigned line_total();
            if (bytes_per_line == '0)
                return int'(MIN_LINE_BYTES);
            if (bytes_per_line > MAX_LINE_BYTES)
                return int'(MAX_LINE_BYTES);
            return int'(bytes_per_line);
        endfunction

        // Queue up to count copies of a byte, stopping early at the line end.
        function void emit_copies(logic [7:0] b, int unsigned count);
            pixel_word_t w;
            int unsigned total;
            int unsigned first;
            int unsigned next_col;
            int unsigned k;
            bit line_end;
            bit done;
            total = line_total();
            for (k = 0; k < count; k++) begin
                w.pixels = b;
                w.row    = row[ROW_OUT_W-1:0];
                w.col    = line_bytes;
                first    = int'(line_bytes) * 8;
                if (int'(image_width) <= first)
                    w.vis = 4'd0;
                else if (int'(image_width) - first >= 8)
                    w.vis = PIX_PER_BYTE;
                else
                    w.vis = 4'(int'(image_width) - first);
                w.last   = 0;
                w.done   = 0;
                done     = 0;
                next_col = int'(line_bytes) + 1;
                line_end = next_col >= total;
                if (line_end) begin
                    line_bytes = '0;
                    row        = row + 1'b1;
                    done       = row >= image_height;
                end else begin
                    line_bytes = COL_W'(next_col);
                end
                if (line_end || k + 1 == count) begin
                    w.last = 1;
                    w.done = done;
                end
                expected_pixels = {expected_pixels, w};
                if (w.last)
                    break;
            end
        endfunction

        // Note one accepted input byte.
        function void take_byte(logic [7:0] b);
            if (image_complete())
                return;
            if (run_pending) begin
                run_pending = 0;
                emit_copies(b, run_length);
            end else if (b[7:6] == RUN_MARK) begin
                run_pending = 1;
                run_length  = b[RUN_W-1:0];
            end else begin
                emit_copies(b, 1);
            end
        endfunction

        function void report(string msg);
            if (mismatches < 10)
                $display("%s", msg);
            mismatches++;
        endfunction

        // Check one accepted result against the oldest expectation.
        function void match_pixels(logic [M_TDATA_W-1:0] tdata, logic tlast, logic tuser);
            pixel_word_t w;
            if (expected_pixels.size() == 0) begin
                report($sformatf("unexpected result: pix=%02h row=%0d col=%0d vis=%0d last=%0b done=%0b",
                                 tdata[7:0], tdata[23:8], tdata[36:24], tdata[40:37],
                                 tlast, tuser));
                return;
            end
            w = expected_pixels.pop_front();
            if (tdata[7:0] !== w.pixels || tdata[23:8] !== w.row || tdata[36:24] !== w.col ||
                tdata[40:37] !== w.vis || tdata[47:41] !== 7'd0 || tlast !== w.last ||
                tuser !== w.done)
                report($sformatf({"result mismatch: expected pix=%02h row=%0d col=%0d vis=%0d ",
                                  "last=%0b done=%0b pad=0, got pix=%02h row=%0d col=%0d ",
                                  "vis=%0d last=%0b done=%0b pad=%0h"},
                                 w.pixels, w.row, w.col, w.vis, w.last, w.done,
                                 tdata[7:0], tdata[23:8], tdata[36:24], tdata[40:37],
                                 tlast, tuser, tdata[47:41]));
        endfunction
    endclass

    logic                     aclk = 0;
    logic                     aresetn = 0;
    logic                     s_tvalid = 0;
    logic                     s_tready;
    logic [7:0]               s_tdata = '0;
    logic                     m_tvalid;
    logic                     m_tready = 0;
    logic [M_TDATA_W-1:0]     m_tdata;
    logic                     m_tlast;
    logic                     m_tuser;
    logic                     cfg_valid = 0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    rle_pixel_predictor pixel_model;
    int                 burst_left = 0;
    int                 decoded_items = 0;
    int                 idle_cycles = 0;
    int                 stall_timer = 0;
    int                 ready_pct = 100;

    pcx_1bpp_rle_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // Receiver: ready follows a duty cycle that changes at random intervals.
    always @(posedge aclk) begin
        if (stall_timer == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pct = 100;
                1: ready_pct = 75;
                2: ready_pct = 50;
                default: ready_pct = 20;
            endcase
            stall_timer = $urandom_range(20, 150);
        end else begin
            stall_timer--;
        end
        m_tready <= ($urandom_range(1, 100) <= ready_pct);
    end

    // Result checking and hang detection.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                pixel_model.match_pixels(m_tdata, m_tlast, m_tuser);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= HANG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Send one byte; the sender idles between bursts of random length.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (!pixel_model.image_complete())
            decoded_items++;
        pixel_model.take_byte(b);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Mostly literals and well-formed runs, with some raw bytes mixed in.
    task automatic send_random_item();
        int unsigned pick;
        int unsigned count;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            send_byte(8'($urandom_range(0, 191)));
        end else if (pick < 80) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                count = 0;
            else if (pick <= 6)
                count = $urandom_range(1, 6);
            else if (pick <= 8)
                count = $urandom_range(7, 40);
            else
                count = $urandom_range(41, 63);
            send_byte({RUN_MARK, 6'(count)});
            send_byte(8'($urandom_range(0, 255)));
        end else begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_random(input int n);
        int target;
        target = decoded_items + n;
        while (decoded_items < target)
            send_random_item();
    endtask

    // Stop sending and wait until every expected result has been transferred.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pixel_model.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write; the caller lowers cfg_valid after the last one.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        pixel_model.write_register(idx, value);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] bpl,
                             input logic [CFG_DATA_W-1:0] width,
                             input logic [CFG_DATA_W-1:0] height);
        wait_drained();
        write_register(CFG_BYTES_PER_LINE, bpl);
        write_register(CFG_IMAGE_WIDTH, width);
        write_register(CFG_SPARE, 17'($urandom_range(0, 131071)));
        write_register(CFG_IMAGE_HEIGHT, height);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        pixel_model = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed bytes at the reset settings: literals at the field extremes,
        // a zero-length run, a run whose data byte looks like a run count,
        // a full 63-byte run, and a run cut short at the end of the line.
        send_byte(8'h00);
        send_byte(8'hBF);
        send_byte(8'h7E);
        send_byte(8'h81);
        send_byte(8'hC0);
        send_byte(8'hFF);
        send_byte(8'hC1);
        send_byte(8'hC7);
        send_byte(8'hFF);
        send_byte(8'h5A);
        send_byte(8'hFF);
        send_byte(8'h3C);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'h01);
        send_byte(8'h80);

        // Zero line length acts as one byte per line, so every run is cut to one.
        configure(17'd0, 17'd1, CFG_ALL_ONES);
        run_random(40);

        // Short lines with a partly visible last byte; pause mid-phase until drained.
        configure(17'd3, 17'd17, CFG_ALL_ONES);
        run_random(20);
        wait_drained();
        run_random(20);

        // Oversized line length saturates; zero width hides every pixel.
        configure(CFG_ALL_ONES, 17'd0, CFG_ALL_ONES);
        run_random(40);

        configure(17'd8192, CFG_ALL_ONES, CFG_ALL_ONES);
        run_random(40);

        // Shorter line than bytes already counted, then decode to the last row
        // and keep sending bytes that must be ignored.
        wait_drained();
        configure(17'd5, 17'd12, 17'(pixel_model.rows_done() + 3));
        while (!pixel_model.image_complete())
            send_random_item();
        repeat (8) send_byte(8'($urandom_range(0, 255)));

        // Zero height: the image is complete from the start.
        configure(17'd1, 17'd12, 17'd0);
        repeat (6) send_byte(8'($urandom_range(0, 255)));

        configure(17'($urandom_range(1, 40)), 17'($urandom_range(1, 400)), CFG_ALL_ONES);
        run_random(80);

        wait_drained();
        repeat (16) @(posedge aclk);
        if (pixel_model.mismatches == 0 && pixel_model.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
